@@ rtl/core/pixel_activity_rss_detector_defines.svh @@
// assertion macros for the pixel activity detector
`ifndef PIXEL_ACTIVITY_RSS_DETECTOR_DEFINES_SVH
`define PIXEL_ACTIVITY_RSS_DETECTOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PARD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PARD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PARD_ASSERT(label, clk, rst_n, prop, msg)
`define PARD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/core/pard_pkg.sv @@
// ----------------------------------------------------------------------------
// pard_pkg
// shared constants and types of the pixel activity detector
// ----------------------------------------------------------------------------
package pard_pkg;
	localparam int MAX_SAMPLES = 1024;
	localparam int MAX_COLS    = 4096;
	localparam int MAX_ROWS    = 4096;
	localparam int ADU_BITS    = 16;

	localparam logic [2:0] REG_GAIN  = 3'd0;
	localparam logic [2:0] REG_RVAR  = 3'd1;
	localparam logic [2:0] REG_CRIT  = 3'd2;
	localparam logic [2:0] REG_NSAMP = 3'd3;
	localparam logic [2:0] REG_NCOLS = 3'd4;
	localparam logic [2:0] REG_NROWS = 3'd5;
	localparam logic [2:0] REG_EMIT  = 3'd6;

	// finished pixel handed from the front to the back
	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [39:0] zsum;
		logic [63:0] zsq;
		logic [16:0] k;
	} pix_t;
endpackage

@@ rtl/core/pixel_activity_rss_detector.sv @@
// a result is offered after its pixel's last sample has passed the front (accept, 22 root
// steps, accumulate), the two-entry queue and the back (capture, square, 80 divide steps, emit)
// the front takes no new sample until the last one is accumulated, and a pixel's
// last sample also holds it until the queue takes the pixel; the back takes no new pixel until the last is out
// reset: arst_n asynchronous active low; registers return to defaults
// ----------------------------------------------------------------------------
// pixel_activity_rss_detector
// variance-stabilised rss per pixel with threshold flag
// ----------------------------------------------------------------------------
`include "pixel_activity_rss_detector_defines.svh"
module pixel_activity_rss_detector #(
	parameter int MAX_SAMPLES = pard_pkg::MAX_SAMPLES,
	parameter int MAX_COLS    = pard_pkg::MAX_COLS,
	parameter int MAX_ROWS    = pard_pkg::MAX_ROWS,
	parameter int ADU_BITS    = pard_pkg::ADU_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] adu,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] pixel_row,
	output logic [11:0] pixel_col,
	output logic [47:0] rss_value,
	output logic        in_roi
);
	logic [23:0] gain_q, rvar_q;
	logic [47:0] crit_q;
	logic [10:0] nsamp_q;
	logic [12:0] ncols_q, nrows_q;
	logic        emit_q;
	logic f_valid, f_ready, b_valid, b_ready;
	pard_pkg::pix_t f_pix, b_pix;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 24'd65536; rvar_q <= '0; crit_q <= '1;
			nsamp_q <= 11'd2; ncols_q <= 13'd1; nrows_q <= 13'd1; emit_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pard_pkg::REG_GAIN:  gain_q <= cfg_data[23:0];
				pard_pkg::REG_RVAR:  rvar_q <= cfg_data[23:0];
				pard_pkg::REG_CRIT:  crit_q <= cfg_data;
				pard_pkg::REG_NSAMP: nsamp_q <= cfg_data[10:0];
				pard_pkg::REG_NCOLS: ncols_q <= cfg_data[12:0];
				pard_pkg::REG_NROWS: nrows_q <= cfg_data[12:0];
				pard_pkg::REG_EMIT:  emit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pard_front #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
		.ADU_BITS(ADU_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .adu(adu),
		.gain_recip(gain_q), .read_variance(rvar_q), .num_samples(nsamp_q),
		.num_cols(ncols_q), .num_rows(nrows_q),
		.pix_valid(f_valid), .pix_ready(f_ready), .pix(f_pix));

	pard_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_pix),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_pix));

	pard_back u_back (
		.clk(clk), .arst_n(arst_n), .pix_valid(b_valid), .pix_ready(b_ready), .pix(b_pix),
		.rss_critical(crit_q), .emit_all(emit_q),
		.out_valid(out_valid), .out_ready(out_ready), .pixel_row(pixel_row),
		.pixel_col(pixel_col), .rss_value(rss_value), .in_roi(in_roi));

	// checks
	`PARD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rss_value), "result dropped while stalled")
	`PARD_ASSERT(a_roi_flag, clk, arst_n, out_valid |-> (emit_q || in_roi), "unflagged pixel emitted")
endmodule

@@ rtl/core/pard_front.sv @@
// ----------------------------------------------------------------------------
// pard_front
// transforms one sample (bit-serial square root) and accumulates per pixel
// ----------------------------------------------------------------------------
module pard_front #(
	parameter int MAX_SAMPLES = pard_pkg::MAX_SAMPLES,
	parameter int MAX_COLS    = pard_pkg::MAX_COLS,
	parameter int MAX_ROWS    = pard_pkg::MAX_ROWS,
	parameter int ADU_BITS    = pard_pkg::ADU_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        adu,
	input  logic [23:0]        gain_recip,
	input  logic [23:0]        read_variance,
	input  logic [10:0]        num_samples,
	input  logic [12:0]        num_cols,
	input  logic [12:0]        num_rows,
	output logic               pix_valid,
	input  logic               pix_ready,
	output pard_pkg::pix_t     pix
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQRT = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [43:0] v_q;
	logic [43:0] res_q;
	logic [4:0]  step_q;
	logic [15:0] sidx_q, col_q, row_q;
	logic [39:0] zsum_q;
	logic [63:0] zsq_q;
	logic [16:0] k_q;

	logic [15:0] adu_m;
	logic [43:0] x4;
	logic [43:0] bitv, trial;
	logic [18:0] z;
	logic [16:0] kc, ncl, nrw;

	assign adu_m = adu & 16'((32'd1 << ADU_BITS) - 1);
	assign x4 = (44'(adu_m) * 44'(gain_recip) + (44'(read_variance) << 8)) << 2;
	assign bitv  = 44'd1 << {step_q, 1'b0};
	assign trial = res_q + bitv;
	assign z = (res_q > 44'h7FFFF) ? 19'h7FFFF : res_q[18:0];

	// clamped sizes
	always_comb begin
		kc  = (num_samples < 11'd2) ? 17'd2 : 17'(num_samples);
		if (kc > 17'(MAX_SAMPLES)) kc = 17'(MAX_SAMPLES);
		ncl = (num_cols == 13'd0) ? 17'd1 : 17'(num_cols);
		if (ncl > 17'(MAX_COLS)) ncl = 17'(MAX_COLS);
		nrw = (num_rows == 13'd0) ? 17'd1 : 17'(num_rows);
		if (nrw > 17'(MAX_ROWS)) nrw = 17'(MAX_ROWS);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign pix_valid = (state_q == ST_OUT);
	assign pix = '{row: row_q[11:0], col: col_q[11:0], zsum: zsum_q, zsq: zsq_q, k: k_q};

	// sequencer: one root bit per cycle, then accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sidx_q <= '0; col_q <= '0; row_q <= '0;
			zsum_q <= '0; zsq_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					v_q <= x4; res_q <= '0; step_q <= 5'd21;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (v_q >= trial) begin
						v_q <= v_q - trial;
						res_q <= (res_q >> 1) + bitv;
					end else begin
						res_q <= res_q >> 1;
					end
					step_q <= step_q - 5'd1;
					if (step_q == 5'd0) state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (17'(sidx_q) + 17'd1 < kc) begin
						zsum_q <= zsum_q + 40'(z);
						zsq_q <= zsq_q + 64'(38'(z) * 38'(z));
						sidx_q <= sidx_q + 16'd1;
						state_q <= ST_IDLE;
					end else begin
						zsum_q <= zsum_q + 40'(z);
						zsq_q <= zsq_q + 64'(38'(z) * 38'(z));
						k_q <= kc;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (pix_ready) begin
					sidx_q <= '0; zsum_q <= '0; zsq_q <= '0;
					if (17'(col_q) + 17'd1 < ncl) col_q <= col_q + 16'd1;
					else begin
						col_q <= '0;
						if (17'(row_q) + 17'd1 < nrw) row_q <= row_q + 16'd1;
						else row_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/pard_fifo.sv @@
// ----------------------------------------------------------------------------
// pard_fifo
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module pard_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  pard_pkg::pix_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output pard_pkg::pix_t rd_data
);
	pard_pkg::pix_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_data;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

@@ rtl/core/pard_back.sv @@
// ----------------------------------------------------------------------------
// pard_back
// forms rss by a restoring division of the square of the low 30 bits of the sum by k, then flags and emits
// ----------------------------------------------------------------------------
module pard_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	output logic           pix_ready,
	input  pard_pkg::pix_t pix,
	input  logic [47:0]    rss_critical,
	input  logic           emit_all,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [11:0]    pixel_row,
	output logic [11:0]    pixel_col,
	output logic [47:0]    rss_value,
	output logic           in_roi
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q;
	pard_pkg::pix_t p_q;
	logic [79:0] sq_q;
	logic [79:0] quo_q;
	logic [16:0] rem_q;
	logic [6:0]  cnt_q;
	logic [17:0] rtry;
	logic [63:0] rss_c;
	logic [47:0] rss;

	assign pix_ready = (state_q == ST_IDLE);
	assign rtry = {rem_q, sq_q[79]};
	assign rss_c = (p_q.zsq >= quo_q[63:0] && quo_q[79:64] == '0) ? p_q.zsq - quo_q[63:0]
		: 64'd0;
	assign rss = (rss_c > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : rss_c[47:0];

	// result valid: set when a finished pixel is emitted, cleared by its beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_valid <= emit_all || (rss >= rss_critical);
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// sequencer: square in the multiply state, then one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (pix_valid) begin
					p_q <= pix;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					sq_q <= 80'(p_q.zsum[29:0]) * 80'(p_q.zsum[29:0]);
					quo_q <= '0; rem_q <= '0; cnt_q <= 7'd80;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					sq_q <= sq_q << 1;
					if (rtry >= 18'(p_q.k)) begin
						rem_q <= 17'(rtry - 18'(p_q.k));
						quo_q <= {quo_q[78:0], 1'b1};
					end else begin
						rem_q <= rtry[16:0];
						quo_q <= {quo_q[78:0], 1'b0};
					end
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) state_q <= ST_OUT;
				end
				ST_OUT: if (!out_valid || out_ready) begin
					if (emit_all || rss >= rss_critical) begin
						pixel_row <= p_q.row;
						pixel_col <= p_q.col;
						rss_value <= rss;
						in_roi <= (rss >= rss_critical);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
